[sv/i2cms_pkg.sv]
package i2cms_pkg;

  // command codes carried by the action field
  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_WRITE     = 3'd3,
    ACT_READ_ACK  = 3'd4,
    ACT_READ_NACK = 3'd5
  } action_e;

  // sequencer steps, one-hot
  typedef enum logic [14:0] {
    STEP_IDLE = 15'b000000000000001,
    STEP_S0   = 15'b000000000000010,
    STEP_S1   = 15'b000000000000100,
    STEP_S2   = 15'b000000000001000,
    STEP_P0   = 15'b000000000010000,
    STEP_P1   = 15'b000000000100000,
    STEP_WA   = 15'b000000001000000,
    STEP_WB   = 15'b000000010000000,
    STEP_WC   = 15'b000000100000000,
    STEP_AA   = 15'b000001000000000,
    STEP_SH   = 15'b000010000000000,
    STEP_AC   = 15'b000100000000000,
    STEP_RA   = 15'b001000000000000,
    STEP_RB   = 15'b010000000000000,
    STEP_FIN  = 15'b100000000000000
  } step_e;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
  localparam logic [2:0] LAST_BIT          = 3'd7;

  // one tick of input
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } tick_t;

  // line and status result of one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } result_t;

endpackage

[sv/i2cms_core.sv]
module i2cms_core import i2cms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] half_period_i,
  input  tick_t      tick_i,
  output result_t    result_o
);

  step_e      step_q, step_d;
  logic [2:0] cmd_q, cmd_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] delay_q, delay_d;
  logic [7:0] shift_q, shift_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       ack_q, ack_d;
  logic [7:0] rx_q, rx_d;

  step_e      phase;
  logic       run;
  logic       done;
  logic [7:0] hold;

  // a zero half period counts as one tick
  assign hold = (half_period_i == 8'd0) ? 8'd1 : half_period_i;

  // next state for one tick
  always_comb begin
    step_d  = step_q;
    cmd_d   = cmd_q;
    bit_d   = bit_q;
    delay_d = delay_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    phase   = step_q;
    run     = 1'b0;
    done    = 1'b0;

    if (step_q == STEP_IDLE) begin
      if (tick_i.action inside {[ACT_START:ACT_READ_NACK]}) begin
        cmd_d = tick_i.action;
        bit_d = 3'd0;
        run   = 1'b1;
        case (tick_i.action)
          ACT_START: phase = STEP_S0;
          ACT_STOP:  phase = STEP_P0;
          ACT_WRITE: begin
            shift_d = tick_i.tx_byte;
            phase   = STEP_WA;
          end
          default: begin
            shift_d = 8'd0;
            phase   = STEP_RA;
          end
        endcase
      end
    end else begin
      delay_d = delay_q - 8'd1;
      run     = (delay_d == 8'd0);
    end

    // run the phase and arm the hold
    if (run) begin
      delay_d = hold;
      case (phase)
        STEP_S0: begin
          sda_d  = 1'b1;
          scl_d  = 1'b1;
          step_d = STEP_S1;
        end
        STEP_S1: begin
          sda_d  = 1'b0;
          step_d = STEP_S2;
        end
        STEP_S2: begin
          scl_d  = 1'b0;
          step_d = STEP_FIN;
        end
        STEP_P0: begin
          sda_d  = 1'b0;
          scl_d  = 1'b1;
          step_d = STEP_P1;
        end
        STEP_P1: begin
          sda_d = 1'b1;
          done  = 1'b1;
        end
        STEP_WA: begin
          sda_d  = shift_d[7];
          step_d = STEP_WB;
        end
        STEP_WB: begin
          scl_d  = 1'b1;
          step_d = STEP_WC;
        end
        STEP_WC: begin
          scl_d   = 1'b0;
          shift_d = {shift_d[6:0], 1'b0};
          if (bit_q == LAST_BIT) begin
            sda_d  = 1'b1;
            step_d = STEP_AA;
          end else begin
            bit_d  = bit_q + 3'd1;
            step_d = STEP_WA;
          end
        end
        STEP_AA: begin
          sda_d  = (cmd_d == ACT_READ_ACK) ? 1'b0 : 1'b1;
          step_d = STEP_SH;
        end
        STEP_SH: begin
          scl_d  = 1'b1;
          step_d = STEP_AC;
        end
        STEP_AC: begin
          if (cmd_d == ACT_WRITE) begin
            ack_d = tick_i.sda_sample;
          end
          scl_d  = 1'b0;
          step_d = (cmd_d == ACT_READ_ACK) ? STEP_P1 : STEP_FIN;
        end
        STEP_RA: begin
          shift_d = {shift_d[6:0], 1'b0};
          if (bit_d == 3'd0) begin
            sda_d = 1'b1;
          end
          scl_d  = 1'b1;
          step_d = STEP_RB;
        end
        STEP_RB: begin
          shift_d = {shift_d[7:1], shift_d[0] | tick_i.sda_sample};
          scl_d   = 1'b0;
          if (bit_q == LAST_BIT) begin
            rx_d   = shift_d;
            step_d = STEP_AA;
          end else begin
            bit_d  = bit_q + 3'd1;
            step_d = STEP_RA;
          end
        end
        default: done = 1'b1;
      endcase
    end

    // finishing tick returns to idle
    if (done) begin
      step_d  = STEP_IDLE;
      delay_d = 8'd0;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_IDLE;
      cmd_q   <= 3'd0;
      bit_q   <= 3'd0;
      delay_q <= 8'd0;
      shift_q <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
      rx_q    <= 8'd0;
    end else if (step_en_i) begin
      step_q  <= step_d;
      cmd_q   <= cmd_d;
      bit_q   <= bit_d;
      delay_q <= delay_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
    end
  end

  // result of this tick
  always_comb begin
    result_o.scl_level = scl_d;
    result_o.sda_level = sda_d;
    result_o.busy_res  = (step_d != STEP_IDLE);
    result_o.done_res  = done;
    result_o.rx_byte   = rx_d;
    result_o.no_ack    = ack_d;
  end

endmodule

[sv/i2c_master_byte_sequencer.sv]
// channel  | signals                                              | dir
// ---------+------------------------------------------------------+-----
// tick in  | in_valid_i, in_ready_o, action_i, tx_byte_i,         | in
//          | sda_sample_i                                         |
// result   | out_valid_o, out_ready_i, scl_level_o, sda_level_o,  | out
//          | busy_res_o, done_res_o, rx_byte_o, no_ack_o          |
// config   | cfg_valid_i, cfg_ready_o, cfg_half_period_ticks_i    | in
//
// one tick per clock cycle sustained while results are taken; a tick's result reaches the
// outputs through the input register, which feeds the sequencer step, which loads
// the result register. the step is a single pass of the sequencer's next-state logic.
// reset clears the sequencer to idle with both lines released and the half
// period at ten ticks. a stalled result holds both registers once the input
// register is full; the input register still takes a tick while the result drains.
module i2c_master_byte_sequencer import i2cms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] tx_byte_i,
  input  logic       sda_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       no_ack_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_half_period_ticks_i
);

  logic [7:0] half_period_q;
  logic       in_valid_q;
  tick_t      tick_q;
  logic       out_valid_q;
  result_t    result_q;
  result_t    result_d;
  logic       advance;
  logic       step_en;

  // pipeline moves when the result slot is free or being taken
  assign advance     = !out_valid_q || out_ready_i;
  assign step_en     = advance && in_valid_q;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
    end else if (cfg_valid_i) begin
      half_period_q <= cfg_half_period_ticks_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q.action     <= action_i;
      tick_q.tx_byte    <= tx_byte_i;
      tick_q.sda_sample <= sda_sample_i;
    end
  end

  // sequencer step
  i2cms_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .half_period_i (half_period_q),
    .tick_i        (tick_q),
    .result_o      (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = result_q.scl_level;
  assign sda_level_o = result_q.sda_level;
  assign busy_res_o  = result_q.busy_res;
  assign done_res_o  = result_q.done_res;
  assign rx_byte_o   = result_q.rx_byte;
  assign no_ack_o    = result_q.no_ack;

endmodule

[tb/i2c_master_byte_sequencer_tb.sv]
`timescale 1ns / 100ps

module i2c_master_byte_sequencer_tb;
  import i2cms_pkg::*;

  // action codes outside the command set, ignored by the sequencer
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  // line states that can be read straight off the command definitions
  localparam result_t LINES_IDLE = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
                                     done_res: 1'b0, rx_byte: 8'h00, no_ack: 1'b0};
  localparam result_t LINES_STOP_SETUP = '{scl_level: 1'b1, sda_level: 1'b0, busy_res: 1'b1,
                                           done_res: 1'b0, rx_byte: 8'h00, no_ack: 1'b0};
  localparam result_t LINES_START_SETUP = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b1,
                                            done_res: 1'b0, rx_byte: 8'h00, no_ack: 1'b0};

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] action_i = ACT_NONE;
  logic [7:0] tx_byte_i = 8'h00;
  logic       sda_sample_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;
  logic       no_ack_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_half_period_ticks_i = 8'h00;

  i2c_master_byte_sequencer i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .action_i               (action_i),
    .tx_byte_i              (tx_byte_i),
    .sda_sample_i           (sda_sample_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .scl_level_o            (scl_level_o),
    .sda_level_o            (sda_level_o),
    .busy_res_o             (busy_res_o),
    .done_res_o             (done_res_o),
    .rx_byte_o              (rx_byte_o),
    .no_ack_o               (no_ack_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_half_period_ticks_i(cfg_half_period_ticks_i)
  );

  // sequencer state mirrored by the line predictor
  logic [7:0] half_period = HALF_PERIOD_RESET;
  step_e      seq_step    = STEP_IDLE;
  action_e    cur_cmd     = ACT_NONE;
  logic [2:0] bit_cnt     = 3'd0;
  logic [7:0] hold_cnt    = 8'd0;
  logic [7:0] shift_q     = 8'd0;
  logic       scl_q       = 1'b1;
  logic       sda_q       = 1'b1;
  logic       nack_q      = 1'b0;
  logic [7:0] rx_q        = 8'd0;

  result_t    pending_lines [$];
  logic [2:0] frame_cmds [$];
  int         mismatches  = 0;

  // sender burst control
  int         burst_left  = 0;
  bit         steady_send = 1'b0;

  // receiver stall control
  bit         hold_req    = 1'b0;
  int         hold_left   = 0;
  logic [31:0] ready_pat  = 32'hFFFF_FFFF;
  logic [4:0] pat_age     = 5'd0;
  result_t    want_lines;

  // directed stimulus row: one command, then filler ticks until it finishes
  typedef struct {
    logic [2:0] act;
    logic [7:0] tx;
    logic       smp;
    logic [2:0] pad_act;
    bit         typed;
    result_t    want;
  } seq_row_t;

  seq_row_t directed_rows [13] = '{
    '{ACT_NONE,      8'h00, 1'b0, ACT_NONE,     1'b1, LINES_IDLE},
    '{ACT_RSVD6,     8'hFF, 1'b1, ACT_NONE,     1'b1, LINES_IDLE},
    '{ACT_RSVD7,     8'h5A, 1'b0, ACT_NONE,     1'b1, LINES_IDLE},
    '{ACT_STOP,      8'h00, 1'b0, ACT_WRITE,    1'b1, LINES_STOP_SETUP},
    '{ACT_START,     8'h00, 1'b1, ACT_RSVD7,    1'b1, LINES_START_SETUP},
    '{ACT_WRITE,     8'hFF, 1'b0, ACT_READ_ACK, 1'b0, LINES_IDLE},
    '{ACT_WRITE,     8'h00, 1'b1, ACT_STOP,     1'b0, LINES_IDLE},
    '{ACT_WRITE,     8'hA5, 1'b0, ACT_START,    1'b0, LINES_IDLE},
    '{ACT_READ_ACK,  8'h00, 1'b1, ACT_WRITE,    1'b0, LINES_IDLE},
    '{ACT_READ_NACK, 8'h00, 1'b0, ACT_RSVD6,    1'b0, LINES_IDLE},
    '{ACT_READ_ACK,  8'h00, 1'b0, ACT_NONE,     1'b0, LINES_IDLE},
    '{ACT_READ_NACK, 8'hFF, 1'b1, ACT_NONE,     1'b0, LINES_IDLE},
    '{ACT_STOP,      8'h00, 1'b0, ACT_NONE,     1'b0, LINES_IDLE}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the handshakes hang
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // load the hold and move on to the next phase
  function automatic void arm_hold(step_e nxt);
    seq_step = nxt;
    hold_cnt = (half_period == 8'd0) ? 8'd1 : half_period;
  endfunction

  // one line phase; returns 1 when the command ends here
  function automatic bit run_phase(logic smp);
    run_phase = 1'b0;
    case (seq_step)
      STEP_S0: begin
        sda_q = 1'b1;
        scl_q = 1'b1;
        arm_hold(STEP_S1);
      end
      STEP_S1: begin
        sda_q = 1'b0;
        arm_hold(STEP_S2);
      end
      STEP_S2: begin
        scl_q = 1'b0;
        arm_hold(STEP_FIN);
      end
      STEP_P0: begin
        sda_q = 1'b0;
        scl_q = 1'b1;
        arm_hold(STEP_P1);
      end
      STEP_P1: begin
        sda_q = 1'b1;
        run_phase = 1'b1;
      end
      STEP_WA: begin
        sda_q = shift_q[7];
        arm_hold(STEP_WB);
      end
      STEP_WB: begin
        scl_q = 1'b1;
        arm_hold(STEP_WC);
      end
      STEP_WC: begin
        scl_q = 1'b0;
        shift_q = {shift_q[6:0], 1'b0};
        if (bit_cnt == LAST_BIT) begin
          sda_q = 1'b1;
          arm_hold(STEP_AA);
        end else begin
          bit_cnt = bit_cnt + 3'd1;
          arm_hold(STEP_WA);
        end
      end
      // ack slot: master drives ack only on a read with ack
      STEP_AA: begin
        sda_q = (cur_cmd == ACT_READ_ACK) ? 1'b0 : 1'b1;
        arm_hold(STEP_SH);
      end
      STEP_SH: begin
        scl_q = 1'b1;
        arm_hold(STEP_AC);
      end
      STEP_AC: begin
        if (cur_cmd == ACT_WRITE) nack_q = smp;
        scl_q = 1'b0;
        if (cur_cmd == ACT_READ_ACK) arm_hold(STEP_P1);
        else arm_hold(STEP_FIN);
      end
      STEP_RA: begin
        shift_q = {shift_q[6:0], 1'b0};
        if (bit_cnt == 3'd0) sda_q = 1'b1;
        scl_q = 1'b1;
        arm_hold(STEP_RB);
      end
      STEP_RB: begin
        shift_q[0] = shift_q[0] | smp;
        scl_q = 1'b0;
        if (bit_cnt == LAST_BIT) begin
          rx_q = shift_q;
          arm_hold(STEP_AA);
        end else begin
          bit_cnt = bit_cnt + 3'd1;
          arm_hold(STEP_RA);
        end
      end
      default: run_phase = 1'b1;
    endcase
  endfunction

  // advance the predicted sequencer by one tick and return its line state
  function automatic result_t step_lines(tick_t tk);
    bit      fin;
    result_t r;
    fin = 1'b0;
    if (seq_step == STEP_IDLE) begin
      if (tk.action >= ACT_START && tk.action <= ACT_READ_NACK) begin
        cur_cmd = action_e'(tk.action);
        bit_cnt = 3'd0;
        case (cur_cmd)
          ACT_START: seq_step = STEP_S0;
          ACT_STOP:  seq_step = STEP_P0;
          ACT_WRITE: begin
            shift_q  = tk.tx_byte;
            seq_step = STEP_WA;
          end
          default: begin
            shift_q  = 8'd0;
            seq_step = STEP_RA;
          end
        endcase
        fin = run_phase(tk.sda_sample);
      end
    end else begin
      hold_cnt = hold_cnt - 8'd1;
      if (hold_cnt == 8'd0) fin = run_phase(tk.sda_sample);
    end
    if (fin) begin
      seq_step = STEP_IDLE;
      hold_cnt = 8'd0;
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (seq_step != STEP_IDLE);
    r.done_res  = fin;
    r.rx_byte   = rx_q;
    r.no_ack    = nack_q;
    return r;
  endfunction

  // offer one tick, wait for its transaction, queue the predicted lines
  task automatic send_tick(input logic [2:0] act, input logic [7:0] tx, input logic smp,
                           input bit typed, input result_t want);
    tick_t   tk;
    result_t predicted;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    tx_byte_i    <= tx;
    sda_sample_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    tk.action     = act;
    tk.tx_byte    = tx;
    tk.sda_sample = smp;
    predicted = step_lines(tk);
    pending_lines.push_back(typed ? want : predicted);
    if (burst_left > 0) burst_left--;
  endtask

  // keep ticking until the running command is over
  task automatic finish_command(input logic [2:0] pad_act, input logic smp);
    while (seq_step != STEP_IDLE)
      send_tick(pad_act, 8'($urandom_range(0, 255)), smp, 1'b0, LINES_IDLE);
  endtask

  // half period write once every queued result is back
  task automatic write_half_period(input logic [7:0] v);
    in_valid_i <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i             <= 1'b1;
    cfg_half_period_ticks_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    half_period = v;
  endtask

  // random ticks: mostly well-formed bus frames, some noise commands
  task automatic random_ticks(input int n);
    int         k;
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      if (seq_step == STEP_IDLE) begin
        if (frame_cmds.size() == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            frame_cmds.push_back(3'($urandom_range(0, 7)));
          end else begin
            frame_cmds.push_back(ACT_START);
            frame_cmds.push_back(ACT_WRITE);
            k = $urandom_range(0, 3);
            repeat (k) frame_cmds.push_back(3'($urandom_range(int'(ACT_WRITE),
                                                               int'(ACT_READ_ACK))));
            if ($urandom_range(0, 1)) frame_cmds.push_back(ACT_READ_NACK);
            frame_cmds.push_back(ACT_STOP);
          end
        end
        act = frame_cmds.pop_front();
      end else begin
        act = 3'($urandom_range(0, 7));
      end
      send_tick(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, LINES_IDLE);
    end
  endtask

  // compare one field and log any difference
  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lines.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got scl %0b sda %0b",
                 $time, scl_level_o, sda_level_o);
        mismatches++;
      end else begin
        want_lines = pending_lines.pop_front();
        check_field("scl_level", want_lines.scl_level, scl_level_o);
        check_field("sda_level", want_lines.sda_level, sda_level_o);
        check_field("busy_res", want_lines.busy_res, busy_res_o);
        check_field("done_res", want_lines.done_res, done_res_o);
        check_field("rx_byte", want_lines.rx_byte, rx_byte_o);
        check_field("no_ack", want_lines.no_ack, no_ack_o);
      end
    end
    // long hold-off on request, otherwise a rotating ready pattern
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
      out_ready_i <= 1'b0;
    end else begin
      if (pat_age == 5'd0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 32'hFFFF_FFFF;
          1: ready_pat = $urandom;
          2: ready_pat = $urandom | $urandom;
          default: ready_pat = 32'h0F0F_FFFF;
        endcase
      end
      out_ready_i <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[31:1]};
      pat_age   = pat_age + 5'd1;
    end
  end

  // main sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed commands: typed rows at the reset half period, the rest at one tick
    foreach (directed_rows[i]) begin
      if (!directed_rows[i].typed && half_period == HALF_PERIOD_RESET)
        write_half_period(8'd1);
      send_tick(directed_rows[i].act, directed_rows[i].tx, directed_rows[i].smp,
                directed_rows[i].typed, directed_rows[i].want);
      finish_command(directed_rows[i].pad_act, directed_rows[i].smp);
    end

    // fastest timing
    write_half_period(8'd1);
    random_ticks(80);
    finish_command(ACT_NONE, 1'($urandom_range(0, 1)));

    // slowest timing, one stop sequence only
    write_half_period(8'd255);
    send_tick(ACT_STOP, 8'($urandom_range(0, 255)), 1'b0, 1'b0, LINES_IDLE);
    finish_command(ACT_START, 1'b1);

    // zero half period behaves as one; receiver backs off while ticks keep coming
    write_half_period(8'd0);
    steady_send = 1'b1;
    hold_req    = 1'b1;
    random_ticks(40);
    steady_send = 1'b0;
    random_ticks(30);

    write_half_period(8'd2);
    random_ticks(20);

    write_half_period(8'd3);
    random_ticks(10);

    // drain
    in_valid_i <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
